// ===== rtl/twst_pkg.sv =====
// ----------------------------------------------------------------------------
// twst_pkg
// Shared types and constants of the temperature window statistics block.
// ----------------------------------------------------------------------------
package twst_pkg;

  // field types
  typedef logic signed [11:0] temp_t;
  typedef logic signed [13:0] wide_temp_t;
  typedef logic [1:0]         mode_t;

  // input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_KEY    = 1'b1;

  // display modes
  localparam mode_t MODE_CURRENT = 2'd0;
  localparam mode_t MODE_MAX     = 2'd1;
  localparam mode_t MODE_MIN     = 2'd2;
  localparam mode_t MODE_AVG     = 2'd3;

  // minimum tracker start value, 500.0 degrees
  localparam wide_temp_t PEAK_LOW_START = 14'sd5000;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_ADD,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/twst_in_if.sv =====
// ----------------------------------------------------------------------------
// twst_in_if
// Input channel: one word is a sample or a select-key event.
// ----------------------------------------------------------------------------
interface twst_in_if;
  import twst_pkg::*;

  logic  valid;
  logic  ready;
  logic  opcode;
  temp_t sample_temp;

  modport source (output valid, output opcode, output sample_temp, input ready);
  modport sink   (input valid, input opcode, input sample_temp, output ready);

endinterface

// ===== rtl/twst_out_if.sv =====
// ----------------------------------------------------------------------------
// twst_out_if
// Result channel: every value plus the one chosen for display.
// ----------------------------------------------------------------------------
interface twst_out_if;
  import twst_pkg::*;

  logic       valid;
  logic       ready;
  temp_t      current_temp;
  temp_t      max_temp;
  wide_temp_t min_temp;
  temp_t      avg_temp;
  mode_t      display_mode;
  wide_temp_t shown_value;

  modport source (
    output valid, output current_temp, output max_temp, output min_temp,
    output avg_temp, output display_mode, output shown_value, input ready
  );
  modport sink (
    input valid, input current_temp, input max_temp, input min_temp,
    input avg_temp, input display_mode, input shown_value, output ready
  );

endinterface

// ===== rtl/twst_ram.sv =====
// ----------------------------------------------------------------------------
// twst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twst_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/temperature_window_statistics.sv =====
// ----------------------------------------------------------------------------
// temperature_window_statistics
// Moving average over the last HISTORY_DEPTH samples with min/max tracking
// and a four-way display mode selector.
// ----------------------------------------------------------------------------
// usage
//   item   : opcode 0 carries a sample in tenths of a degree, opcode 1 is a
//            select-key release that steps the display mode
//   result : one word per item with current, max, min, average, the mode
//            and the value the mode selects
//   a sample runs through evict, add, prep, a sign-magnitude restoring
//   divider with one quotient bit per cycle over SUM_W = 12 +
//   clog2(HISTORY_DEPTH) bits and a final sign fix before the result word
//   is loaded; a key event goes straight to the output step; the next item
//   can be accepted once the result word has been loaded
//   one item is in work at a time; ready is high only while idle
//   the result sits in an output register; while it waits the next item is
//   accepted and computed, then held until the receiver takes the first
//   reset clears all statistics and the mode; the sample ring is not
//   cleared, an entry is read only after it has been written
// ----------------------------------------------------------------------------
module temperature_window_statistics #(
  parameter int HISTORY_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  twst_in_if.sink   item,
  twst_out_if.source result
);
  import twst_pkg::*;

  localparam int SUM_W  = 12 + $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
  localparam int ITER_W = $clog2(SUM_W);

  state_t state, state_next;

  logic [SLOT_W-1:0]       write_slot;
  logic [CNT_W-1:0]        fill_count;
  logic signed [SUM_W-1:0] window_sum;
  temp_t                   latest_sample;
  temp_t                   peak_high;
  wide_temp_t              peak_low;
  temp_t                   mean_value;
  mode_t                   mode_index;
  temp_t                   new_sample;

  // divider registers
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic              quo_neg;
  logic [ITER_W-1:0] iter;

  // output register
  logic       res_valid;
  temp_t      res_current;
  temp_t      res_max;
  wide_temp_t res_min;
  temp_t      res_avg;
  mode_t      res_mode;
  wide_temp_t res_shown;

  // control
  logic accept;
  logic ring_full;
  logic ram_we;
  logic ram_re;
  logic load_out;
  logic div_last;
  logic [11:0] ram_rdata;

  assign accept    = item.valid && item.ready;
  assign ring_full = fill_count == CNT_W'(HISTORY_DEPTH);
  assign div_last  = iter == ITER_W'(SUM_W - 1);

  // sample ring
  twst_ram #(
    .WIDTH (12),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (new_sample),
    .re    (ram_re),
    .raddr (write_slot),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (item.opcode == OP_KEY) ? ST_OUT : ST_EVICT;
        end
      end
      ST_EVICT: state_next = ST_ADD;
      ST_ADD:   state_next = ST_PREP;
      ST_PREP:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: state_next = ST_OUT;
      ST_OUT: begin
        if (!res_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item.ready = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        ram_re     = item.valid && item.opcode == OP_SAMPLE;
      end
      ST_ADD: ram_we = 1'b1;
      ST_OUT: load_out = !res_valid || result.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider step: shift in one dividend bit, subtract when it fits
  logic [CNT_W:0] rem_sh;
  logic [CNT_W:0] rem_diff;
  logic           rem_ge;

  always_comb begin
    rem_sh   = {rem, quo[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, fill_count};
    rem_ge   = rem_sh >= {1'b0, fill_count};
  end

  // statistics datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      fill_count    <= '0;
      window_sum    <= '0;
      latest_sample <= '0;
      peak_high     <= '0;
      peak_low      <= PEAK_LOW_START;
      mean_value    <= '0;
      mode_index    <= MODE_CURRENT;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && item.opcode == OP_KEY) begin
            mode_index <= mode_index + 2'd1;
          end
        end
        ST_EVICT: begin
          latest_sample <= new_sample;
          if (ring_full) begin
            window_sum <= window_sum - SUM_W'(temp_t'(ram_rdata));
          end else begin
            fill_count <= fill_count + CNT_W'(1);
          end
          if (new_sample > peak_high) begin
            peak_high <= new_sample;
          end
          if (wide_temp_t'(new_sample) < peak_low) begin
            peak_low <= wide_temp_t'(new_sample);
          end
        end
        ST_ADD: begin
          window_sum <= window_sum + SUM_W'(new_sample);
          if (write_slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
            write_slot <= '0;
          end else begin
            write_slot <= write_slot + SLOT_W'(1);
          end
        end
        ST_FIX: begin
          mean_value <= quo_neg ? temp_t'(-quo) : temp_t'(quo);
        end
        default: begin
        end
      endcase
    end
  end

  // sample latch and divider, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      new_sample <= item.sample_temp;
    end
    if (state == ST_PREP) begin
      quo_neg <= window_sum[SUM_W-1];
      quo     <= window_sum[SUM_W-1] ? -window_sum : window_sum;
      rem     <= '0;
      iter    <= '0;
    end else if (state == ST_DIV) begin
      quo  <= {quo[SUM_W-2:0], rem_ge};
      rem  <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      iter <= iter + ITER_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_current <= latest_sample;
      res_max     <= peak_high;
      res_min     <= peak_low;
      res_avg     <= mean_value;
      res_mode    <= mode_index;
      case (mode_index)
        MODE_MAX: res_shown <= wide_temp_t'(peak_high);
        MODE_MIN: res_shown <= peak_low;
        MODE_AVG: res_shown <= wide_temp_t'(mean_value);
        default:  res_shown <= wide_temp_t'(latest_sample);
      endcase
    end
  end

  assign result.valid        = res_valid;
  assign result.current_temp = res_current;
  assign result.max_temp     = res_max;
  assign result.min_temp     = res_min;
  assign result.avg_temp     = res_avg;
  assign result.display_mode = res_mode;
  assign result.shown_value  = res_shown;

  // fill count saturates at the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(HISTORY_DEPTH))
    else $error("fill count above depth");

  // ring pointer stays inside the ring
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_W'(HISTORY_DEPTH - 1))
    else $error("write slot out of range");

  // divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> fill_count != '0)
    else $error("divide by zero count");

  // a key event leaves the window untouched
  a_key_keeps_sum: assert property (@(posedge clk) disable iff (rst)
    accept && item.opcode == OP_KEY |=> $stable(window_sum) && $stable(fill_count))
    else $error("key event changed window");

endmodule

// ===== tb/sv/twst_stats_checker.sv =====
// ----------------------------------------------------------------------------
// twst_stats_checker
// Watches both channels of the temperature window statistics block. Every
// accepted item word runs through a local copy of the window, peak and mode
// state to build the expected result word. Every accepted result word is
// compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module twst_stats_checker (
  input  logic clk,
  input  logic rst,
  twst_in_if   item_mon,
  twst_out_if  result_mon,
  output int   failures,
  output int   outstanding,
  output int   words_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import twst_pkg::*;

  localparam int DEPTH      = 16;
  localparam int PRINT_CAP  = 40;

  // one expected result word
  typedef struct {
    temp_t      current;
    temp_t      highest;
    wide_temp_t lowest;
    temp_t      average;
    mode_t      mode;
    wide_temp_t shown;
  } reading_t;

  // local copy of the block state
  temp_t      window [DEPTH];
  int         slot;
  int         filled;
  int         window_total;
  temp_t      latest;
  temp_t      highest;
  wide_temp_t lowest;
  temp_t      average;
  mode_t      mode;

  reading_t   expected_readings [$];
  int         printed;

  // step the statistics by one item word and build the word it returns
  function automatic reading_t predict_reading(logic op, temp_t t);
    reading_t r;
    if (op == OP_KEY) begin
      mode = mode_t'(mode + 2'd1);
    end else begin
      latest = t;
      // oldest entry leaves the sum only once the window is full
      if (filled >= DEPTH) begin
        window_total -= int'(window[slot]);
      end else begin
        filled++;
      end
      window[slot] = t;
      window_total += int'(t);
      slot = (slot + 1) % DEPTH;
      if (t > highest) highest = t;
      if (wide_temp_t'(t) < lowest) lowest = wide_temp_t'(t);
      average = temp_t'(window_total / filled);
    end
    r.current = latest;
    r.highest = highest;
    r.lowest  = lowest;
    r.average = average;
    r.mode    = mode;
    case (mode)
      MODE_MAX: r.shown = wide_temp_t'(highest);
      MODE_MIN: r.shown = lowest;
      MODE_AVG: r.shown = wide_temp_t'(average);
      default:  r.shown = wide_temp_t'(latest);
    endcase
    return r;
  endfunction

  // one line per mismatch, printing capped, counting not
  task automatic report_mismatch(string what, int got, int want);
    failures++;
    if (printed < PRINT_CAP) begin
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      printed++;
    end
  endtask

  // monitor both channels at the rising edge
  always @(posedge clk) begin : monitor
    reading_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) window[i] = '0;
      slot          = 0;
      filled        = 0;
      window_total  = 0;
      latest        = '0;
      highest       = '0;
      lowest        = PEAK_LOW_START;
      average       = '0;
      mode          = MODE_CURRENT;
      printed       = 0;
      failures      = 0;
      words_checked = 0;
      expected_readings.delete();
    end else begin
      // result side first: a result never belongs to a word taken this edge
      if (result_mon.valid && result_mon.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result word with nothing expected",
                          int'(result_mon.shown_value), 0);
        end else begin
          want = expected_readings.pop_front();
          words_checked++;
          if (result_mon.current_temp !== want.current)
            report_mismatch("current_temp", int'(result_mon.current_temp), int'(want.current));
          if (result_mon.max_temp !== want.highest)
            report_mismatch("max_temp", int'(result_mon.max_temp), int'(want.highest));
          if (result_mon.min_temp !== want.lowest)
            report_mismatch("min_temp", int'(result_mon.min_temp), int'(want.lowest));
          if (result_mon.avg_temp !== want.average)
            report_mismatch("avg_temp", int'(result_mon.avg_temp), int'(want.average));
          if (result_mon.display_mode !== want.mode)
            report_mismatch("display_mode", int'(result_mon.display_mode), int'(want.mode));
          if (result_mon.shown_value !== want.shown)
            report_mismatch("shown_value", int'(result_mon.shown_value), int'(want.shown));
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        expected_readings.push_back(predict_reading(item_mon.opcode, item_mon.sample_temp));
      end
    end
    outstanding <= expected_readings.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives samples and select-key words into the temperature window statistics
// block in bursts with random gaps, stalls the result side on its own
// pattern, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import twst_pkg::*;

  localparam int RANDOM_WORDS = 950;

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;
  int   words_checked;
  int   samples_sent;
  int   keys_sent;
  int   burst_left;

  twst_in_if  item_ch ();
  twst_out_if result_ch ();

  temperature_window_statistics dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  twst_stats_checker stats_check (
    .clk           (clk),
    .rst           (rst),
    .item_mon      (item_ch),
    .result_mon    (result_ch),
    .failures      (failures),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d result words still expected", outstanding);
    $display("** temperature_window_statistics: FAILED **");
    $finish;
  end

  // receiver stalls, in a style that is picked anew at random during the run
  initial begin : receiver
    int cycle;
    int style;
    cycle = 0;
    style = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycle % 97 == 0) style = $urandom_range(0, 3);
      case (style)
        0:       result_ch.ready = 1'b1;
        1:       result_ch.ready = 1'($urandom_range(0, 1));
        2:       result_ch.ready = ($urandom_range(0, 24) == 0);
        default: result_ch.ready = (cycle % 3 == 0);
      endcase
      cycle++;
    end
  end

  // send one word, starting and ending at a falling edge
  task automatic send_word(logic op, temp_t t);
    // gap between bursts
    if (burst_left == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    item_ch.valid       = 1'b1;
    item_ch.opcode      = op;
    item_ch.sample_temp = t;
    do @(posedge clk); while (!item_ch.ready);
    if (op == OP_KEY) keys_sent++;
    else samples_sent++;
    @(negedge clk);
  endtask

  // mostly plausible readings, some extremes and raw 12-bit patterns
  function automatic temp_t pick_temp();
    case ($urandom_range(0, 19))
      0:       return temp_t'($urandom_range(0, 4095));
      1:       return -12'sd550;
      2:       return 12'sd1500;
      3:       return -12'sd2048;
      4:       return 12'sd2047;
      default: return temp_t'(int'($urandom_range(0, 2050)) - 550);
    endcase
  endfunction

  function automatic temp_t pick_extreme();
    case ($urandom_range(0, 3))
      0:       return -12'sd2048;
      1:       return 12'sd2047;
      2:       return -12'sd550;
      default: return 12'sd1500;
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int sent;
    int run;
    temp_t level;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.opcode      = OP_SAMPLE;
    item_ch.sample_temp = '0;
    samples_sent        = 0;
    keys_sent           = 0;
    burst_left          = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // key presses before any sample: peaks at start values, full mode wrap
    send_word(OP_KEY, 12'sd0);
    send_word(OP_KEY, 12'sd2047);
    send_word(OP_KEY, -12'sd2048);
    send_word(OP_KEY, 12'sd0);
    // negative samples keep the maximum at zero
    send_word(OP_SAMPLE, -12'sd550);
    send_word(OP_SAMPLE, -12'sd2048);
    send_word(OP_KEY, 12'sd0);
    send_word(OP_KEY, 12'sd0);
    send_word(OP_KEY, 12'sd0);
    // field extremes and out-of-range patterns
    send_word(OP_SAMPLE, 12'sd2047);
    send_word(OP_SAMPLE, 12'sd1500);
    send_word(OP_SAMPLE, -12'sd1);
    send_word(OP_SAMPLE, 12'sd1);
    send_word(OP_KEY, 12'sd0);
    send_word(OP_SAMPLE, 12'sd0);
    send_word(OP_KEY, 12'sd0);
    send_word(OP_KEY, 12'sd0);
    send_word(OP_SAMPLE, -12'sd7);
    send_word(OP_KEY, 12'sd0);
    send_word(OP_KEY, 12'sd0);
    send_word(OP_SAMPLE, 12'sd555);

    // random words, with occasional runs long enough to fill the window
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      run = $urandom_range(0, 99);
      if (run < 3) begin
        level = pick_extreme();
        repeat (20) send_word(OP_SAMPLE, level);
        sent += 20;
      end else if (run < 18) begin
        send_word(OP_KEY, temp_t'($urandom_range(0, 4095)));
        sent++;
      end else begin
        send_word(OP_SAMPLE, pick_temp());
        sent++;
      end
    end
    item_ch.valid = 1'b0;

    // drain
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d samples and %0d key words, %0d result words checked",
             samples_sent, keys_sent, words_checked);
    if (failures == 0) begin
      $display("** temperature_window_statistics: PASSED **");
    end else begin
      $display("%0d mismatches", failures);
      $display("** temperature_window_statistics: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/twst_pkg.sv
rtl/twst_in_if.sv
rtl/twst_out_if.sv
rtl/twst_ram.sv
rtl/temperature_window_statistics.sv
tb/sv/twst_stats_checker.sv
tb/sv/testbench.sv
